// File: design/pdsc_pkg.sv
// Shared types and constants of the power data object selection block.
package pdsc_pkg;

    localparam int MAX_OBJECTS = 7;
    localparam int POS_W = $clog2(MAX_OBJECTS + 1);

    localparam int FIELD_W = 10;
    localparam int VOLT_W = 6;
    localparam logic [VOLT_W-1:0] REQ_VOLT_RESET = 6'd5;

    // One whole volt is this many 50 mV steps.
    localparam int VOLT_STEPS = 1000 / 50;
    localparam int THRESH_W = FIELD_W + 1;

    // No USB Suspend and USB Communication Capable, bits 25 and 24.
    localparam logic [1:0] REQ_FLAGS = 2'b11;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        KIND_FIXED     = 2'd0,
        KIND_BATTERY   = 2'd1,
        KIND_VARIABLE  = 2'd2,
        KIND_AUGMENTED = 2'd3
    } pdo_kind_t;

    typedef struct packed {
        logic               usable;
        logic               in_range;
        logic [POS_W-1:0]   pos;
        pdo_kind_t          kind;
        logic [FIELD_W-1:0] min_volts;
        logic [FIELD_W-1:0] max_volts;
        logic [FIELD_W-1:0] max_current;
        logic [FIELD_W-1:0] max_power;
        logic               last;
    } obj_entry_t;

endpackage

// File: design/pdsc_if.sv
// Handshake interfaces for the object input channel and the request output channel.
interface pdsc_obj_if;
    logic        valid;
    logic        ready;
    logic [31:0] power_object;
    logic        last_object;

    modport source (output valid, output power_object, output last_object, input ready);
    modport sink (input valid, input power_object, input last_object, output ready);
endinterface

interface pdsc_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] request_word;
    logic [2:0]  object_position;
    logic [1:0]  contract_kind;
    logic [9:0]  contract_min_volts;
    logic [9:0]  contract_max_volts;
    logic [9:0]  contract_peak_current;
    logic [9:0]  contract_max_power;
    logic        no_match;

    modport source (output valid, output request_word, output object_position,
                    output contract_kind, output contract_min_volts,
                    output contract_max_volts, output contract_peak_current,
                    output contract_max_power, output no_match, input ready);
    modport sink (input valid, input request_word, input object_position,
                  input contract_kind, input contract_min_volts,
                  input contract_max_volts, input contract_peak_current,
                  input contract_max_power, input no_match, output ready);
endinterface

// File: design/pd_source_cap_select_request_core.sv
// Top level of the source capability selection and request block.
//
// Objects of a source capabilities message arrive on the objects channel, one
// transaction per power data object, with last_object set on the final one.
// Only the final object produces a transaction on the request channel: the
// request data object together with the chosen contract, or no_match when
// nothing usable was offered. Objects beyond the seventh are ignored.
// The request voltage register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, which the block does not enforce.
// An object can be taken every cycle while the queue is not full. The front end
// decodes it in the accepting cycle and writes it into a two-entry queue; the
// back end updates the running choice as each object leaves the queue. The request
// is held in an output register, loaded when the back end pops the final object.
// When the receiver stalls, the output register holds the request and the
// queue absorbs up to two further objects before objects.ready drops.
// Reset sets the request voltage to 5 V, empties the queue and clears the
// running choice and the object count.
module pd_source_cap_select_request_core (
    input  logic                        clk,
    input  logic                        rst_n,
    pdsc_obj_if.sink                    objects,
    pdsc_req_if.source                  request,
    input  logic                        cfg_we,
    input  logic [pdsc_pkg::VOLT_W-1:0] cfg_wdata
);
    import pdsc_pkg::*;

    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    obj_entry_t push_data;
    obj_entry_t pop_data;

    pdsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .objects   (objects),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fifo_full (full),
        .push      (push),
        .push_data (push_data)
    );

    pdsc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    pdsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .request  (request)
    );

endmodule

// File: design/pdsc_front.sv
// Front end: accepts objects, decodes them and holds the request voltage register.
module pdsc_front (
    input  logic                            clk,
    input  logic                            rst_n,
    pdsc_obj_if.sink                        objects,
    input  logic                            cfg_we,
    input  logic [pdsc_pkg::VOLT_W-1:0]     cfg_wdata,
    input  logic                            fifo_full,
    output logic                            push,
    output pdsc_pkg::obj_entry_t            push_data
);
    import pdsc_pkg::*;

    logic [VOLT_W-1:0]   req_volt_reg;
    logic [POS_W-1:0]    count_reg;
    logic [POS_W-1:0]    count_next;
    logic                room;
    logic [THRESH_W-1:0] threshold;
    pdo_kind_t           kind;

    assign objects.ready = !fifo_full;
    assign push = objects.valid && !fifo_full;
    assign room = count_reg < POS_W'(MAX_OBJECTS);

    // floor(volts * 50 / 1000) <= V holds exactly when volts < 20 * (V + 1).
    assign threshold = THRESH_W'(req_volt_reg) * THRESH_W'(VOLT_STEPS)
                       + THRESH_W'(VOLT_STEPS - 1);

    assign kind = pdo_kind_t'(objects.power_object[31:30]);

    always_comb
    begin
        push_data = '0;
        push_data.kind = kind;
        push_data.pos = count_reg;
        push_data.last = objects.last_object;
        unique case (kind)
            KIND_FIXED:
            begin
                push_data.max_volts = objects.power_object[19:10];
                push_data.max_current = objects.power_object[9:0];
            end
            KIND_BATTERY:
            begin
                push_data.min_volts = objects.power_object[19:10];
                push_data.max_volts = objects.power_object[29:20];
                push_data.max_power = objects.power_object[9:0];
            end
            KIND_VARIABLE:
            begin
                push_data.min_volts = objects.power_object[19:10];
                push_data.max_volts = objects.power_object[29:20];
                push_data.max_current = objects.power_object[9:0];
            end
            KIND_AUGMENTED:
            begin
                push_data.kind = KIND_AUGMENTED;
            end
        endcase
        push_data.usable = room && (kind != KIND_AUGMENTED);
        push_data.in_range = {1'b0, push_data.max_volts} <= threshold;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push)
        begin
            if (objects.last_object)
                count_next = '0;
            else if (room)
                count_next = count_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            req_volt_reg <= REQ_VOLT_RESET;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
                req_volt_reg <= cfg_wdata;
        end
    end

endmodule

// File: design/pdsc_fifo.sv
// Short queue of decoded objects between the front end and the back end.
module pdsc_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pdsc_pkg::obj_entry_t push_data,
    output logic                 full,
    input  logic                 pop,
    output pdsc_pkg::obj_entry_t pop_data,
    output logic                 empty
);
    import pdsc_pkg::*;

    obj_entry_t           store_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     fill_reg;

    assign full = fill_reg == (FIFO_AW + 1)'(FIFO_DEPTH);
    assign empty = fill_reg == '0;
    assign pop_data = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                              : wr_ptr_reg + FIFO_AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
                              : rd_ptr_reg + FIFO_AW'(1);
            if (push && !pop)
                fill_reg <= fill_reg + (FIFO_AW + 1)'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - (FIFO_AW + 1)'(1);
        end
    end

endmodule

// File: design/pdsc_back.sv
// Back end: keeps the running choice and forms the request on the final object.
module pdsc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  pdsc_pkg::obj_entry_t pop_data,
    output logic                 pop,
    pdsc_req_if.source           request
);
    import pdsc_pkg::*;

    logic               have_reg;
    logic [POS_W-1:0]   index_reg;
    pdo_kind_t          kind_reg;
    logic [FIELD_W-1:0] min_reg;
    logic [FIELD_W-1:0] max_reg;
    logic [FIELD_W-1:0] cur_reg;
    logic [FIELD_W-1:0] pwr_reg;

    logic               have_next;
    logic [POS_W-1:0]   index_next;
    pdo_kind_t          kind_next;
    logic [FIELD_W-1:0] min_next;
    logic [FIELD_W-1:0] max_next;
    logic [FIELD_W-1:0] cur_next;
    logic [FIELD_W-1:0] pwr_next;

    logic               out_valid_reg;
    logic [31:0]        word_reg;
    logic [POS_W-1:0]   position_reg;
    pdo_kind_t          out_kind_reg;
    logic [FIELD_W-1:0] out_min_reg;
    logic [FIELD_W-1:0] out_max_reg;
    logic [FIELD_W-1:0] out_cur_reg;
    logic [FIELD_W-1:0] out_pwr_reg;
    logic               no_match_reg;

    logic               take;
    logic [POS_W-1:0]   position;
    logic [FIELD_W-1:0] req_value;

    assign pop = !empty && (!out_valid_reg || request.ready);
    assign take = pop_data.usable && (!have_reg || pop_data.in_range);

    always_comb
    begin
        have_next = have_reg;
        index_next = index_reg;
        kind_next = kind_reg;
        min_next = min_reg;
        max_next = max_reg;
        cur_next = cur_reg;
        pwr_next = pwr_reg;
        if (take)
        begin
            have_next = 1'b1;
            index_next = pop_data.pos;
            kind_next = pop_data.kind;
            min_next = pop_data.min_volts;
            max_next = pop_data.max_volts;
            cur_next = pop_data.max_current;
            pwr_next = pop_data.max_power;
        end
    end

    assign position = have_next ? index_next + POS_W'(1) : '0;
    assign req_value = (cur_next != '0) ? cur_next : pwr_next;

    always_ff @(posedge clk)
    begin
        if (pop && pop_data.last)
        begin
            word_reg <= {1'b0, position, 2'b00, REQ_FLAGS, 4'b0000, req_value, req_value};
            position_reg <= position;
            out_kind_reg <= kind_next;
            out_min_reg <= min_next;
            out_max_reg <= max_next;
            out_cur_reg <= cur_next;
            out_pwr_reg <= pwr_next;
            no_match_reg <= !have_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            have_reg <= 1'b0;
            index_reg <= '0;
            kind_reg <= KIND_FIXED;
            min_reg <= '0;
            max_reg <= '0;
            cur_reg <= '0;
            pwr_reg <= '0;
        end
        else
        begin
            if (pop && pop_data.last)
                out_valid_reg <= 1'b1;
            else if (request.ready)
                out_valid_reg <= 1'b0;

            if (pop)
            begin
                // The final object closes the message, so the choice starts over.
                if (pop_data.last)
                begin
                    have_reg <= 1'b0;
                    index_reg <= '0;
                    kind_reg <= KIND_FIXED;
                    min_reg <= '0;
                    max_reg <= '0;
                    cur_reg <= '0;
                    pwr_reg <= '0;
                end
                else
                begin
                    have_reg <= have_next;
                    index_reg <= index_next;
                    kind_reg <= kind_next;
                    min_reg <= min_next;
                    max_reg <= max_next;
                    cur_reg <= cur_next;
                    pwr_reg <= pwr_next;
                end
            end
        end
    end

    assign request.valid = out_valid_reg;
    assign request.request_word = word_reg;
    assign request.object_position = position_reg;
    assign request.contract_kind = out_kind_reg;
    assign request.contract_min_volts = out_min_reg;
    assign request.contract_max_volts = out_max_reg;
    assign request.contract_peak_current = out_cur_reg;
    assign request.contract_max_power = out_pwr_reg;
    assign request.no_match = no_match_reg;

endmodule

// File: tb/pd_source_cap_select_request_core_tb.sv
// Self-checking testbench for the source capability selection and request block.
module pd_source_cap_select_request_core_tb;
    import pdsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 10;
    localparam int PHASE_ITEMS = 250;

    typedef struct packed {
        logic [31:0]        word;
        logic [POS_W-1:0]   position;
        pdo_kind_t          kind;
        logic [FIELD_W-1:0] min_volts;
        logic [FIELD_W-1:0] max_volts;
        logic [FIELD_W-1:0] max_current;
        logic [FIELD_W-1:0] max_power;
        logic               no_match;
    } request_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [VOLT_W-1:0] cfg_wdata;

    pdsc_obj_if obj_ch();
    pdsc_req_if req_ch();

    pd_source_cap_select_request_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .objects   (obj_ch),
        .request   (req_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Running selection as the block should hold it.
    logic [VOLT_W-1:0]  volt_limit;
    logic [POS_W-1:0]   seen_count;
    logic               sel_valid;
    logic [POS_W-1:0]   sel_slot;
    pdo_kind_t          sel_kind;
    logic [FIELD_W-1:0] sel_min;
    logic [FIELD_W-1:0] sel_max;
    logic [FIELD_W-1:0] sel_cur;
    logic [FIELD_W-1:0] sel_pow;
    int                 msg_len;

    request_t pending_requests[$];

    int fail_count = 0;
    int objects_sent = 0;
    int messages_sent = 0;
    int empty_messages = 0;
    int long_messages = 0;
    int requests_checked = 0;
    int voltage_writes = 0;

    // Sender and receiver pacing.
    bit          src_bursty = 1'b0;
    int          burst_left = 0;
    bit          rcv_stall = 1'b0;
    int          hold_left = 0;
    logic [7:0]  stall_pattern = 8'hA5;
    int          pattern_age = 0;

    task automatic clear_selection();
        seen_count = '0;
        sel_valid = 1'b0;
        sel_slot = '0;
        sel_kind = KIND_FIXED;
        sel_min = '0;
        sel_max = '0;
        sel_cur = '0;
        sel_pow = '0;
        msg_len = 0;
    endtask

    task automatic absorb_object(input logic [31:0] obj, input logic last_flag);
        pdo_kind_t          k;
        logic [FIELD_W-1:0] mn;
        logic [FIELD_W-1:0] mx;
        logic [FIELD_W-1:0] cu;
        logic [FIELD_W-1:0] pw;
        logic [FIELD_W-1:0] req_value;
        logic [POS_W-1:0]   slot;
        request_t           r;
        int                 whole_volts;
        objects_sent++;
        msg_len++;
        if (seen_count < POS_W'(MAX_OBJECTS))
        begin
            k = pdo_kind_t'(obj[31:30]);
            mn = '0;
            mx = '0;
            cu = '0;
            pw = '0;
            slot = seen_count;
            seen_count = seen_count + POS_W'(1);
            if (k != KIND_AUGMENTED)
            begin
                case (k)
                    KIND_FIXED:
                    begin
                        mx = obj[19:10];
                        cu = obj[9:0];
                    end
                    KIND_BATTERY:
                    begin
                        mn = obj[19:10];
                        mx = obj[29:20];
                        pw = obj[9:0];
                    end
                    default:
                    begin
                        mn = obj[19:10];
                        mx = obj[29:20];
                        cu = obj[9:0];
                    end
                endcase
                whole_volts = (int'(mx) * 50) / 1000;
                if (!sel_valid || whole_volts <= int'(volt_limit))
                begin
                    sel_valid = 1'b1;
                    sel_slot = slot;
                    sel_kind = k;
                    sel_min = mn;
                    sel_max = mx;
                    sel_cur = cu;
                    sel_pow = pw;
                end
            end
        end
        if (last_flag)
        begin
            r.position = sel_valid ? sel_slot + POS_W'(1) : '0;
            req_value = (sel_cur != '0) ? sel_cur : sel_pow;
            r.word = {1'b0, r.position, 2'b00, REQ_FLAGS, 4'b0000, req_value, req_value};
            r.kind = sel_kind;
            r.min_volts = sel_min;
            r.max_volts = sel_max;
            r.max_current = sel_cur;
            r.max_power = sel_pow;
            r.no_match = !sel_valid;
            pending_requests.push_back(r);
            messages_sent++;
            if (!sel_valid)
                empty_messages++;
            if (msg_len > MAX_OBJECTS)
                long_messages++;
            clear_selection();
        end
    endtask

    // Offers one object and returns at the clock edge that accepts it.
    task automatic send_object(input logic [31:0] obj, input logic last_flag);
        int gap;
        if (src_bursty)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 8);
                if (gap > 0)
                begin
                    @(negedge clk);
                    obj_ch.valid = 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        @(negedge clk);
        obj_ch.valid = 1'b1;
        obj_ch.power_object = obj;
        obj_ch.last_object = last_flag;
        do
            @(posedge clk);
        while (!obj_ch.ready);
        absorb_object(obj, last_flag);
    endtask

    task automatic stop_objects();
        @(negedge clk);
        obj_ch.valid = 1'b0;
    endtask

    task automatic wait_for_requests();
        while (pending_requests.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_voltage_limit(input logic [VOLT_W-1:0] volts);
        stop_objects();
        wait_for_requests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = volts;
        @(negedge clk);
        cfg_we = 1'b0;
        volt_limit = volts;
        voltage_writes++;
    endtask

    function automatic logic [31:0] rand_object();
        logic [31:0]        raw;
        logic [FIELD_W-1:0] mn;
        logic [FIELD_W-1:0] mx;
        logic [FIELD_W-1:0] cu;
        logic [FIELD_W-1:0] pw;
        logic [FIELD_W-1:0] spare;
        int                 pick;
        int                 v;
        raw = $urandom;
        pick = $urandom_range(0, 9);
        mn = FIELD_W'($urandom_range(0, 1023));
        pw = FIELD_W'($urandom_range(0, 1023));
        spare = FIELD_W'($urandom_range(0, 1023));
        cu = ($urandom_range(0, 3) == 0) ? '0 : FIELD_W'($urandom_range(0, 1023));
        if (pick < 2)
            return raw;
        if (pick == 2)
            return {KIND_AUGMENTED, raw[29:0]};
        // Objects from picks 3 to 6 sit close to the voltage limit so the floor comparison is exercised.
        if (pick < 7)
        begin
            v = int'(volt_limit) + int'($urandom_range(0, 4)) - 2;
            if (v < 0)
                v = 0;
            v = v * VOLT_STEPS + int'($urandom_range(0, VOLT_STEPS - 1));
            if (v > 1023)
                v = 1023;
            mx = v[FIELD_W-1:0];
        end
        else
            mx = FIELD_W'($urandom_range(0, 1023));
        case ($urandom_range(0, 2))
            0: return {KIND_FIXED, spare, mx, cu};
            1: return {KIND_BATTERY, mx, mn, pw};
            default: return {KIND_VARIABLE, mx, mn, cu};
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Receiver: always ready, a rotating stall pattern, or a long hold-off.
    initial
    begin
        req_ch.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                req_ch.ready = 1'b0;
                hold_left--;
            end
            else if (rcv_stall)
            begin
                pattern_age++;
                if (pattern_age >= 64)
                begin
                    pattern_age = 0;
                    stall_pattern = 8'($urandom_range(1, 255));
                end
                stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
                req_ch.ready = stall_pattern[0];
            end
            else
                req_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        request_t e;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            if (pending_requests.size() == 0)
            begin
                $error("request transaction with no expectation waiting");
                fail_count++;
            end
            else
            begin
                e = pending_requests.pop_front();
                requests_checked++;
                check_field("request_word", e.word, req_ch.request_word);
                check_field("object_position", 32'(e.position), 32'(req_ch.object_position));
                check_field("contract_kind", 32'(e.kind), 32'(req_ch.contract_kind));
                check_field("contract_min_volts", 32'(e.min_volts),
                            32'(req_ch.contract_min_volts));
                check_field("contract_max_volts", 32'(e.max_volts),
                            32'(req_ch.contract_max_volts));
                check_field("contract_peak_current", 32'(e.max_current),
                            32'(req_ch.contract_peak_current));
                check_field("contract_max_power", 32'(e.max_power),
                            32'(req_ch.contract_max_power));
                check_field("no_match", 32'(e.no_match), 32'(req_ch.no_match));
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (obj_ch.valid && obj_ch.ready) || (req_ch.valid && req_ch.ready) || cfg_we)
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("pd_source_cap_select_request_core_tb NOT OK");
                $finish;
            end
        end
    end

    // Every object kind on its own with all payload bits high, and a fixed object with all bits low.
    task automatic test_single_kinds();
        send_object(32'h0000_0000, 1'b1);
        send_object(32'h3FFF_FFFF, 1'b1);
        send_object(32'h7FFF_FFFF, 1'b1);
        send_object(32'hBFFF_FFFF, 1'b1);
        send_object(32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_no_usable();
        send_object({KIND_AUGMENTED, 30'h0}, 1'b0);
        send_object({KIND_AUGMENTED, 30'h1555_5555}, 1'b0);
        send_object({KIND_AUGMENTED, 30'h2AAA_AAAA}, 1'b1);
        send_object(32'hC000_0000, 1'b1);
    endtask

    // With the reset limit of 5 V: 5.95 V replaces, 6 V does not, exactly 5 V does.
    task automatic test_replacement();
        send_object({KIND_FIXED, 10'd0, 10'd400, 10'd300}, 1'b0);
        send_object({KIND_VARIABLE, 10'd119, 10'd100, 10'd200}, 1'b0);
        send_object({KIND_FIXED, 10'd0, 10'd120, 10'd100}, 1'b0);
        send_object({KIND_BATTERY, 10'd100, 10'd60, 10'd40}, 1'b1);
    endtask

    // Objects past the seventh are dropped, yet the final mark still produces the request.
    task automatic test_overflow();
        for (int i = 0; i < MAX_OBJECTS; i++)
            send_object({KIND_FIXED, 10'd0, 10'd400, 10'(i + 1)}, 1'b0);
        send_object({KIND_FIXED, 10'd0, 10'd100, 10'd55}, 1'b0);
        send_object({KIND_AUGMENTED, 30'h0}, 1'b1);
    endtask

    task automatic test_backpressure();
        src_bursty = 1'b0;
        rcv_stall = 1'b0;
        stop_objects();
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 10; i++)
            send_object(rand_object(), (i % 3) != 1);
        stop_objects();
        wait_for_requests();
    endtask

    task automatic run_random_phase(input logic [VOLT_W-1:0] volts, input bit bursty,
                                    input bit stalls);
        int count;
        int len;
        write_voltage_limit(volts);
        src_bursty = bursty;
        rcv_stall = stalls;
        count = 0;
        while (count < PHASE_ITEMS)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(1, 7);
            for (int i = 0; i < len; i++)
                send_object(rand_object(), i == len - 1);
            count += len;
        end
    endtask

    task automatic test_random();
        run_random_phase(6'd0, 1'b1, 1'b1);
        run_random_phase(6'd63, 1'b0, 1'b0);
        run_random_phase(VOLT_W'($urandom_range(0, 63)), 1'b1, 1'b0);
        run_random_phase(VOLT_W'($urandom_range(0, 63)), 1'b0, 1'b1);
        run_random_phase(REQ_VOLT_RESET, 1'b1, 1'b1);
        run_random_phase(VOLT_W'($urandom_range(0, 20)), 1'b1, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        obj_ch.valid = 1'b0;
        obj_ch.power_object = '0;
        obj_ch.last_object = 1'b0;
        volt_limit = REQ_VOLT_RESET;
        clear_selection();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_kinds();
        test_no_usable();
        test_replacement();
        test_overflow();
        test_backpressure();
        test_random();

        stop_objects();
        wait_for_requests();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d objects in %0d capability messages, %0d requests checked.",
                 objects_sent, messages_sent, requests_checked);
        $display("%0d messages had no usable object, %0d ran past seven objects, %0d limits set.",
                 empty_messages, long_messages, voltage_writes);
        if (fail_count == 0)
            $display("pd_source_cap_select_request_core_tb OK");
        else
            $display("pd_source_cap_select_request_core_tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
design/pdsc_pkg.sv
design/pdsc_if.sv
design/pdsc_front.sv
design/pdsc_fifo.sv
design/pdsc_back.sv
design/pd_source_cap_select_request_core.sv
tb/pd_source_cap_select_request_core_tb.sv
